@@ src/tobi_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the 2-opt search block.
package tobi_pkg;

  localparam int MAX_NODES = 64;
  localparam int COST_BITS = 16;
  localparam int OUT_LIMIT = 64;

  localparam int MAX_POS = (MAX_NODES < OUT_LIMIT) ? MAX_NODES : OUT_LIMIT;
  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int POS_W   = $clog2(MAX_POS);
  localparam int CNT_W   = $clog2(MAX_POS + 1);
  localparam int CMP_W   = POS_W + 1;

  localparam int COST_DEPTH = 1 << (2 * NODE_W);

  // port field widths
  localparam int OPC_W   = 2;
  localparam int FNODE_W = 6;
  localparam int VAL_W   = 16;
  localparam int CNTF_W  = 7;

  localparam int GAIN_W   = COST_BITS + 2;
  localparam int TOTAL_W  = 22;
  localparam int SUM_W    = ((GAIN_W > TOTAL_W) ? GAIN_W : TOTAL_W) + 1;
  localparam int GAIN_MAX = 4194303;

  typedef enum logic [OPC_W-1:0] {
    OP_COST  = 2'd0,
    OP_ROUTE = 2'd1,
    OP_RUN   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    RA_I,
    RA_J,
    RA_SWAP,
    RA_EMIT
  } raddr_e;

  typedef enum logic [1:0] {
    CA_RD,
    CA_PB,
    CA_ABN
  } caddr_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PASS,
    S_RD_I,
    S_PA,
    S_CPA,
    S_RD_J,
    S_C1,
    S_C2,
    S_C3,
    S_C4,
    S_END,
    S_SW_RD,
    S_SW_W1,
    S_SW_W2,
    S_EM_RD,
    S_EM_OUT
  } state_e;

  typedef struct packed {
    logic   ld_cost;
    logic   ld_route;
    logic   run_start;
    logic   pass_init;
    raddr_e rt_sel;
    caddr_e cost_sel;
    logic   lat_pa;
    logic   lat_cpa;
    logic   lat_bbn;
    logic   acc_load;
    logic   acc_sub;
    logic   cmp;
    logic   j_next;
    logic   i_next;
    logic   swap_init;
    logic   sw_w1;
    logic   sw_w2;
    logic   emit_out;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic n_short;
    logic j_more;
    logic i_more;
    logic gain_pos;
    logic swap_more;
    logic k_last;
  } sts_t;

endpackage

@@ src/tobi_ctrl.sv @@
// Sequencer for loads, 2-opt passes, segment reversal and route output.
module tobi_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tobi_pkg::OPC_W-1:0]   opcode_i,
  input  tobi_pkg::sts_t               sts_i,
  output tobi_pkg::cmd_t               cmd_o,
  output logic                         busy_o
);

  tobi_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tobi_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rt_sel   = tobi_pkg::RA_I;
    cmd_o.cost_sel = tobi_pkg::CA_RD;
    busy_o  = (state_q != tobi_pkg::S_IDLE);
    case (state_q)
      tobi_pkg::S_IDLE: begin
        if (start_i) begin
          case (tobi_pkg::opcode_e'(opcode_i))
            tobi_pkg::OP_COST:  cmd_o.ld_cost  = 1'b1;
            tobi_pkg::OP_ROUTE: cmd_o.ld_route = 1'b1;
            tobi_pkg::OP_RUN: begin
              if (!sts_i.cnt_zero) begin
                cmd_o.run_start = 1'b1;
                state_d = tobi_pkg::S_PASS;
              end
            end
            default: ;
          endcase
        end
      end
      tobi_pkg::S_PASS: begin
        cmd_o.pass_init = 1'b1;
        state_d = sts_i.n_short ? tobi_pkg::S_EM_RD : tobi_pkg::S_RD_I;
      end
      tobi_pkg::S_RD_I: begin
        cmd_o.rt_sel = tobi_pkg::RA_I;
        state_d = tobi_pkg::S_PA;
      end
      tobi_pkg::S_PA: begin
        cmd_o.lat_pa   = 1'b1;
        cmd_o.cost_sel = tobi_pkg::CA_RD;
        state_d = tobi_pkg::S_CPA;
      end
      tobi_pkg::S_CPA: begin
        cmd_o.lat_cpa = 1'b1;
        cmd_o.rt_sel  = tobi_pkg::RA_J;
        state_d = tobi_pkg::S_C1;
      end
      tobi_pkg::S_RD_J: begin
        cmd_o.rt_sel = tobi_pkg::RA_J;
        state_d = tobi_pkg::S_C1;
      end
      tobi_pkg::S_C1: begin
        cmd_o.lat_bbn  = 1'b1;
        cmd_o.cost_sel = tobi_pkg::CA_RD;
        state_d = tobi_pkg::S_C2;
      end
      tobi_pkg::S_C2: begin
        cmd_o.acc_load = 1'b1;
        cmd_o.cost_sel = tobi_pkg::CA_PB;
        state_d = tobi_pkg::S_C3;
      end
      tobi_pkg::S_C3: begin
        cmd_o.acc_sub  = 1'b1;
        cmd_o.cost_sel = tobi_pkg::CA_ABN;
        state_d = tobi_pkg::S_C4;
      end
      tobi_pkg::S_C4: begin
        cmd_o.cmp = 1'b1;
        if (sts_i.j_more) begin
          cmd_o.j_next = 1'b1;
          state_d = tobi_pkg::S_RD_J;
        end else if (sts_i.i_more) begin
          cmd_o.i_next = 1'b1;
          state_d = tobi_pkg::S_RD_I;
        end else begin
          state_d = tobi_pkg::S_END;
        end
      end
      tobi_pkg::S_END: begin
        if (sts_i.gain_pos) begin
          cmd_o.swap_init = 1'b1;
          state_d = tobi_pkg::S_SW_RD;
        end else begin
          state_d = tobi_pkg::S_EM_RD;
        end
      end
      tobi_pkg::S_SW_RD: begin
        cmd_o.rt_sel = tobi_pkg::RA_SWAP;
        state_d = tobi_pkg::S_SW_W1;
      end
      tobi_pkg::S_SW_W1: begin
        cmd_o.sw_w1 = 1'b1;
        state_d = tobi_pkg::S_SW_W2;
      end
      tobi_pkg::S_SW_W2: begin
        cmd_o.sw_w2 = 1'b1;
        state_d = sts_i.swap_more ? tobi_pkg::S_SW_RD : tobi_pkg::S_PASS;
      end
      tobi_pkg::S_EM_RD: begin
        cmd_o.rt_sel = tobi_pkg::RA_EMIT;
        state_d = tobi_pkg::S_EM_OUT;
      end
      tobi_pkg::S_EM_OUT: begin
        cmd_o.emit_out = 1'b1;
        state_d = sts_i.k_last ? tobi_pkg::S_IDLE : tobi_pkg::S_EM_RD;
      end
      default: state_d = tobi_pkg::S_IDLE;
    endcase
  end

endmodule

@@ src/tobi_datapath.sv @@
// Cost and route memories, pair counters, gain arithmetic and result outputs.
module tobi_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tobi_pkg::cmd_t                  cmd_i,
  output tobi_pkg::sts_t                  sts_o,
  input  logic [tobi_pkg::FNODE_W-1:0]    row_node_i,
  input  logic [tobi_pkg::FNODE_W-1:0]    col_node_i,
  input  logic [tobi_pkg::VAL_W-1:0]      cost_value_i,
  input  logic [tobi_pkg::FNODE_W-1:0]    route_pos_i,
  input  logic [tobi_pkg::FNODE_W-1:0]    route_node_i,
  input  logic [tobi_pkg::CNTF_W-1:0]     route_count_i,
  output logic                            valid_o,
  output logic [tobi_pkg::FNODE_W-1:0]    out_pos_o,
  output logic [tobi_pkg::FNODE_W-1:0]    out_node_o,
  output logic [tobi_pkg::TOTAL_W-1:0]    total_gain_o,
  output logic                            last_o
);

  localparam int PW = tobi_pkg::POS_W;
  localparam int CW = tobi_pkg::CMP_W;
  localparam int NW = tobi_pkg::NODE_W;
  localparam int FW = tobi_pkg::FNODE_W;
  localparam int KB = tobi_pkg::COST_BITS;
  localparam int GW = tobi_pkg::GAIN_W;

  // memories
  logic [FW-1:0]   route_mem [tobi_pkg::MAX_POS];
  logic [KB-1:0]   cost_mem  [tobi_pkg::COST_DEPTH];

  logic [FW-1:0]   rd0_q, rd1_q;
  logic [KB-1:0]   cost_q;
  logic            oor_q;

  // counters and working registers
  logic [tobi_pkg::CNT_W-1:0] n_q, n_d;
  logic [PW-1:0]   i_q, i_d, j_q, j_d, k_q, k_d, lo_q, lo_d, hi_q, hi_d;
  logic [PW-1:0]   best_i_q, best_i_d, best_j_q, best_j_d;
  logic [FW-1:0]   p_q, p_d, a_q, a_d, b_q, b_d, bn_q, bn_d, tmp_q, tmp_d;
  logic [KB-1:0]   cpa_q, cpa_d;
  logic signed [GW-1:0] acc_q, acc_d, best_q, best_d;
  logic [tobi_pkg::TOTAL_W-1:0] gsum_q, gsum_d;

  logic [CW-1:0]   nx, j_inc;
  logic [PW-1:0]   jn;
  logic [PW-1:0]   ra0, ra1;
  logic            rt_we;
  logic [PW-1:0]   rt_waddr;
  logic [FW-1:0]   rt_wdata;
  logic            pos_ok;

  logic [FW-1:0]   cu, cv, cmin, cmax, ld_min, ld_max;
  logic            c_oor, ld_ok;
  logic [2*NW-1:0] c_raddr, c_waddr;

  logic [KB-1:0]   cost_rd;
  logic signed [GW-1:0] cost_s, cpa_s, diff;
  logic [tobi_pkg::SUM_W-1:0] sum;
  logic [tobi_pkg::CNTF_W-1:0] cnt_sat;

  assign nx    = CW'(n_q);
  assign j_inc = CW'(j_q) + CW'(1);
  assign jn    = (j_inc == nx) ? '0 : PW'(j_inc);

  // route read addresses
  always_comb begin
    case (cmd_i.rt_sel)
      tobi_pkg::RA_I:    begin ra0 = i_q - PW'(1); ra1 = i_q;  end
      tobi_pkg::RA_J:    begin ra0 = j_q;          ra1 = jn;   end
      tobi_pkg::RA_SWAP: begin ra0 = lo_q;         ra1 = hi_q; end
      tobi_pkg::RA_EMIT: begin ra0 = k_q;          ra1 = k_q;  end
      default:           begin ra0 = k_q;          ra1 = k_q;  end
    endcase
  end

  assign pos_ok   = (32'(route_pos_i) < tobi_pkg::MAX_POS);
  assign rt_we    = (cmd_i.ld_route && pos_ok) || cmd_i.sw_w1 || cmd_i.sw_w2;
  assign rt_waddr = cmd_i.ld_route ? PW'(route_pos_i) : (cmd_i.sw_w1 ? lo_q : hi_q);
  assign rt_wdata = cmd_i.ld_route ? route_node_i : (cmd_i.sw_w1 ? rd1_q : tmp_q);

  always_ff @(posedge clk_i) begin
    if (rt_we) begin
      route_mem[rt_waddr] <= rt_wdata;
    end
    rd0_q <= route_mem[ra0];
    rd1_q <= route_mem[ra1];
  end

  // cost matrix keeps one entry per unordered pair, at (min, max)
  always_comb begin
    case (cmd_i.cost_sel)
      tobi_pkg::CA_RD:  begin cu = rd0_q; cv = rd1_q; end
      tobi_pkg::CA_PB:  begin cu = p_q;   cv = b_q;   end
      tobi_pkg::CA_ABN: begin cu = a_q;   cv = bn_q;  end
      default:          begin cu = rd0_q; cv = rd1_q; end
    endcase
  end

  assign cmin    = (cu < cv) ? cu : cv;
  assign cmax    = (cu < cv) ? cv : cu;
  assign c_oor   = (32'(cu) >= tobi_pkg::MAX_NODES) || (32'(cv) >= tobi_pkg::MAX_NODES);
  assign c_raddr = {NW'(cmin), NW'(cmax)};

  assign ld_min  = (row_node_i < col_node_i) ? row_node_i : col_node_i;
  assign ld_max  = (row_node_i < col_node_i) ? col_node_i : row_node_i;
  assign ld_ok   = (32'(row_node_i) < tobi_pkg::MAX_NODES) &&
                   (32'(col_node_i) < tobi_pkg::MAX_NODES);
  assign c_waddr = {NW'(ld_min), NW'(ld_max)};

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_cost && ld_ok) begin
      cost_mem[c_waddr] <= KB'(cost_value_i);
    end
    cost_q <= cost_mem[c_raddr];
    oor_q  <= c_oor;
  end

  assign cost_rd = oor_q ? '0 : cost_q;
  assign cost_s  = $signed({2'b00, cost_rd});
  assign cpa_s   = $signed({2'b00, cpa_q});
  assign diff    = acc_q - cost_s;
  assign sum     = tobi_pkg::SUM_W'(gsum_q) + tobi_pkg::SUM_W'($unsigned(best_q));
  assign cnt_sat = (route_count_i > tobi_pkg::CNTF_W'(tobi_pkg::MAX_POS)) ?
                   tobi_pkg::CNTF_W'(tobi_pkg::MAX_POS) : route_count_i;

  always_comb begin
    n_d = n_q;  i_d = i_q;  j_d = j_q;  k_d = k_q;  lo_d = lo_q;  hi_d = hi_q;
    best_i_d = best_i_q;  best_j_d = best_j_q;  best_d = best_q;
    p_d = p_q;  a_d = a_q;  b_d = b_q;  bn_d = bn_q;  tmp_d = tmp_q;
    cpa_d = cpa_q;  acc_d = acc_q;  gsum_d = gsum_q;
    if (cmd_i.run_start) begin
      n_d    = tobi_pkg::CNT_W'(cnt_sat);
      gsum_d = '0;
      k_d    = '0;
    end
    if (cmd_i.pass_init) begin
      best_d   = '0;
      best_i_d = '0;
      best_j_d = '0;
      i_d      = PW'(1);
      j_d      = PW'(2);
    end
    if (cmd_i.lat_pa) begin
      p_d = rd0_q;
      a_d = rd1_q;
    end
    if (cmd_i.lat_cpa) cpa_d = cost_rd;
    if (cmd_i.lat_bbn) begin
      b_d  = rd0_q;
      bn_d = rd1_q;
    end
    if (cmd_i.acc_load) acc_d = cpa_s + cost_s;
    if (cmd_i.acc_sub)  acc_d = acc_q - cost_s;
    if (cmd_i.cmp && (diff > best_q)) begin
      best_d   = diff;
      best_i_d = i_q;
      best_j_d = j_q;
    end
    if (cmd_i.j_next) j_d = j_q + PW'(1);
    if (cmd_i.i_next) begin
      i_d = i_q + PW'(1);
      j_d = PW'(CW'(i_q) + CW'(2));
    end
    if (cmd_i.swap_init) begin
      lo_d   = best_i_q;
      hi_d   = best_j_q;
      gsum_d = (sum > tobi_pkg::SUM_W'(tobi_pkg::GAIN_MAX)) ?
               tobi_pkg::TOTAL_W'(tobi_pkg::GAIN_MAX) : tobi_pkg::TOTAL_W'(sum);
    end
    if (cmd_i.sw_w1) tmp_d = rd0_q;
    if (cmd_i.sw_w2) begin
      lo_d = lo_q + PW'(1);
      hi_d = hi_q - PW'(1);
    end
    if (cmd_i.emit_out) k_d = k_q + PW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;  i_q <= '0;  j_q <= '0;  k_q <= '0;  lo_q <= '0;  hi_q <= '0;
      best_i_q <= '0;  best_j_q <= '0;  best_q <= '0;  gsum_q <= '0;
    end else begin
      n_q <= n_d;  i_q <= i_d;  j_q <= j_d;  k_q <= k_d;  lo_q <= lo_d;  hi_q <= hi_d;
      best_i_q <= best_i_d;  best_j_q <= best_j_d;  best_q <= best_d;  gsum_q <= gsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;  a_q <= a_d;  b_q <= b_d;  bn_q <= bn_d;  tmp_q <= tmp_d;
    cpa_q <= cpa_d;  acc_q <= acc_d;
  end

  assign sts_o.cnt_zero  = (route_count_i == '0);
  assign sts_o.n_short   = (nx < CW'(3));
  assign sts_o.j_more    = (j_inc < nx);
  assign sts_o.i_more    = ((CW'(i_q) + CW'(2)) < nx);
  assign sts_o.gain_pos  = (best_q > 0);
  assign sts_o.swap_more = ((CW'(lo_q) + CW'(2)) < CW'(hi_q));
  assign sts_o.k_last    = ((CW'(k_q) + CW'(1)) == nx);

  assign valid_o      = cmd_i.emit_out;
  assign out_pos_o    = FW'(k_q);
  assign out_node_o   = rd0_q;
  assign total_gain_o = gsum_q;
  assign last_o       = cmd_i.emit_out && sts_o.k_last;

endmodule

@@ src/two_opt_best_improvement.sv @@
// Load request: busy_o stays low and the next request can be taken in the following cycle.
// Run request (n positions): for n >= 3, a pass scans all pairs for the best gain, the four link
// costs on one cost-memory port; no scan for n < 3. A positive gain swaps position pairs and runs
// a new pass, else each entry is emitted; busy_o is high, no request taken.
// Results are strobed by valid_o for one cycle each; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) returns to idle; memory contents hold until written.
module two_opt_best_improvement (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [tobi_pkg::OPC_W-1:0]      opcode_i,
  input  logic [tobi_pkg::FNODE_W-1:0]    row_node_i,
  input  logic [tobi_pkg::FNODE_W-1:0]    col_node_i,
  input  logic [tobi_pkg::VAL_W-1:0]      cost_value_i,
  input  logic [tobi_pkg::FNODE_W-1:0]    route_pos_i,
  input  logic [tobi_pkg::FNODE_W-1:0]    route_node_i,
  input  logic [tobi_pkg::CNTF_W-1:0]     route_count_i,
  output logic                            valid_o,
  output logic [tobi_pkg::FNODE_W-1:0]    out_pos_o,
  output logic [tobi_pkg::FNODE_W-1:0]    out_node_o,
  output logic [tobi_pkg::TOTAL_W-1:0]    total_gain_o,
  output logic                            last_o
);

  tobi_pkg::cmd_t cmd;
  tobi_pkg::sts_t sts;

  tobi_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  tobi_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .row_node_i    (row_node_i),
    .col_node_i    (col_node_i),
    .cost_value_i  (cost_value_i),
    .route_pos_i   (route_pos_i),
    .route_node_i  (route_node_i),
    .route_count_i (route_count_i),
    .valid_o       (valid_o),
    .out_pos_o     (out_pos_o),
    .out_node_o    (out_node_o),
    .total_gain_o  (total_gain_o),
    .last_o        (last_o)
  );

endmodule

@@ src/tobi_checker.sv @@
// Port-level checks on result sequencing, bound to the top level.
module tobi_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          valid_o,
  input logic [tobi_pkg::FNODE_W-1:0]  out_pos_o,
  input logic [tobi_pkg::TOTAL_W-1:0]  total_gain_o,
  input logic                          last_o
);

  // results only appear while a run request is in progress
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("result strobe outside a run");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> valid_o)
    else $error("last without result strobe");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !busy_o)
    else $error("block still busy after final entry");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> !valid_o)
    else $error("request taken while a result is strobed");

  // consecutive entries: next position, same total gain
  a_next_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> ##2 (valid_o &&
      out_pos_o == tobi_pkg::FNODE_W'($past(out_pos_o, 2) + 1'b1) &&
      total_gain_o == $past(total_gain_o, 2)))
    else $error("route entries out of sequence");

endmodule

bind two_opt_best_improvement tobi_checker u_tobi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .valid_o      (valid_o),
  .out_pos_o    (out_pos_o),
  .total_gain_o (total_gain_o),
  .last_o       (last_o)
);

@@ sim/two_opt_best_improvement_tb.sv @@
// Self-checking testbench for the best-improvement 2-opt route search block.
`timescale 1ns / 1ps

module two_opt_best_improvement_tb;
  import tobi_pkg::*;

  localparam int RANDOM_REQUESTS = 430;
  localparam int MAX_GAP         = 6;
  localparam int WATCHDOG_CYCLES = 1000000;
  localparam int DRAIN_CYCLES    = 64;

  typedef struct {
    opcode_e             op;
    logic [FNODE_W-1:0]  row;
    logic [FNODE_W-1:0]  col;
    logic [VAL_W-1:0]    cost;
    logic [FNODE_W-1:0]  pos;
    logic [FNODE_W-1:0]  node;
    logic [CNTF_W-1:0]   count;
    bit                  hold;   // not a request: wait until the block has drained
  } request_t;

  typedef struct {
    logic [FNODE_W-1:0] pos;
    logic [FNODE_W-1:0] node;
    logic [TOTAL_W-1:0] gain;
    logic               last;
  } tour_entry_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start_i       = 1'b0;
  logic [OPC_W-1:0]    opcode_i      = '0;
  logic [FNODE_W-1:0]  row_node_i    = '0;
  logic [FNODE_W-1:0]  col_node_i    = '0;
  logic [VAL_W-1:0]    cost_value_i  = '0;
  logic [FNODE_W-1:0]  route_pos_i   = '0;
  logic [FNODE_W-1:0]  route_node_i  = '0;
  logic [CNTF_W-1:0]   route_count_i = '0;
  logic                busy_o;
  logic                valid_o;
  logic [FNODE_W-1:0]  out_pos_o;
  logic [FNODE_W-1:0]  out_node_o;
  logic [TOTAL_W-1:0]  total_gain_o;
  logic                last_o;

  two_opt_best_improvement dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .row_node_i    (row_node_i),
    .col_node_i    (col_node_i),
    .cost_value_i  (cost_value_i),
    .route_pos_i   (route_pos_i),
    .route_node_i  (route_node_i),
    .route_count_i (route_count_i),
    .valid_o       (valid_o),
    .out_pos_o     (out_pos_o),
    .out_node_o    (out_node_o),
    .total_gain_o  (total_gain_o),
    .last_o        (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  request_t    request_q[$];
  tour_entry_t tour_expect_q[$];
  int          mismatches = 0;

  // predictor copy of the block's memories
  logic [COST_BITS-1:0] cost_mem [COST_DEPTH];
  logic [NODE_W-1:0]    route_mem [MAX_NODES];

  // stimulus bookkeeping: which cost entries exist, and how long a route prefix
  // only holds nodes whose mutual costs are all loaded
  bit  cost_known [COST_DEPTH];
  int  ready_len = 0;
  int  sent = 0;
  int  set_nodes [8];
  int  set_size = 0;
  int  route_plan [64];

  function automatic longint link_cost(input logic [NODE_W-1:0] u, input logic [NODE_W-1:0] v);
    return longint'(cost_mem[int'(u) * MAX_NODES + int'(v)]);
  endfunction

  task automatic optimize_route(input int n);
    longint      best, diff, total;
    int          i, j, nxt, bi, bj, lo, hi, k;
    logic [NODE_W-1:0] tmp;
    tour_entry_t e;
    total = 0;
    do begin
      best = 0;
      bi = 0;
      bj = 0;
      for (i = 1; i + 1 < n; i++) begin
        for (j = i + 1; j < n; j++) begin
          nxt = (j + 1 == n) ? 0 : j + 1;
          diff = link_cost(route_mem[i-1], route_mem[i]) + link_cost(route_mem[j], route_mem[nxt])
               - link_cost(route_mem[i-1], route_mem[j]) - link_cost(route_mem[i], route_mem[nxt]);
          // strict compare keeps the first pair among equal gains
          if (diff > best) begin
            best = diff;
            bi = i;
            bj = j;
          end
        end
      end
      if (best > 0) begin
        lo = bi;
        hi = bj;
        while (lo < hi) begin
          tmp = route_mem[lo];
          route_mem[lo] = route_mem[hi];
          route_mem[hi] = tmp;
          lo++;
          hi--;
        end
        total = total + best;
        if (total > GAIN_MAX) total = GAIN_MAX;
      end
    end while (best > 0);
    for (k = 0; k < n; k++) begin
      e.pos  = FNODE_W'(k);
      e.node = route_mem[k];
      e.gain = total[TOTAL_W-1:0];
      e.last = (k == n - 1);
      tour_expect_q.push_back(e);
    end
  endtask

  task automatic absorb_request(input request_t r);
    int n;
    case (r.op)
      OP_COST: begin
        // mirrored write keeps the matrix symmetric
        cost_mem[int'(r.row) * MAX_NODES + int'(r.col)] = r.cost[COST_BITS-1:0];
        cost_mem[int'(r.col) * MAX_NODES + int'(r.row)] = r.cost[COST_BITS-1:0];
      end
      OP_ROUTE: route_mem[r.pos] = r.node;
      OP_RUN: begin
        n = (int'(r.count) > MAX_POS) ? MAX_POS : int'(r.count);
        if (n > 0) optimize_route(n);
      end
      default: ;
    endcase
  endtask

  function automatic request_t fresh_request();
    request_t r;
    r.op    = OP_NONE;
    r.row   = FNODE_W'($urandom_range(0, 63));
    r.col   = FNODE_W'($urandom_range(0, 63));
    r.cost  = VAL_W'($urandom_range(0, 65535));
    r.pos   = FNODE_W'($urandom_range(0, 63));
    r.node  = FNODE_W'($urandom_range(0, 63));
    r.count = CNTF_W'($urandom_range(0, 127));
    r.hold  = 1'b0;
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] cost_draw();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return VAL_W'($urandom_range(0, 15));
      default: return VAL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_cost(input int u, input int v, input logic [VAL_W-1:0] val);
    request_t r;
    r = fresh_request();
    r.op   = OP_COST;
    r.row  = FNODE_W'(u);
    r.col  = FNODE_W'(v);
    r.cost = val;
    request_q.push_back(r);
    cost_known[u * MAX_NODES + v] = 1'b1;
    cost_known[v * MAX_NODES + u] = 1'b1;
    sent++;
  endtask

  task automatic push_route(input int p, input int node);
    request_t r;
    r = fresh_request();
    r.op   = OP_ROUTE;
    r.pos  = FNODE_W'(p);
    r.node = FNODE_W'(node);
    request_q.push_back(r);
    if (p < ready_len) ready_len = p;
    sent++;
  endtask

  task automatic push_run(input int count);
    request_t r;
    r = fresh_request();
    r.op    = OP_RUN;
    r.count = CNTF_W'(count);
    request_q.push_back(r);
    sent++;
  endtask

  task automatic push_noop();
    request_t r;
    r = fresh_request();
    r.op = OP_NONE;
    request_q.push_back(r);
  endtask

  task automatic push_hold();
    request_t r;
    r = fresh_request();
    r.hold = 1'b1;
    request_q.push_back(r);
  endtask

  task automatic choose_nodes(input int k);
    int a, b;
    bit dup;
    for (a = 0; a < k; a++) begin
      do begin
        set_nodes[a] = $urandom_range(0, 63);
        dup = 1'b0;
        for (b = 0; b < a; b++) if (set_nodes[b] == set_nodes[a]) dup = 1'b1;
      end while (dup);
    end
    set_size = k;
  endtask

  // load every missing cost among the chosen nodes, diagonal included;
  // now and then reload a known one to exercise overrides
  task automatic cover_set();
    int a, b, u, v;
    for (a = 0; a < set_size; a++) begin
      for (b = a; b < set_size; b++) begin
        u = set_nodes[a];
        v = set_nodes[b];
        if (!cost_known[u * MAX_NODES + v] || $urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1)) push_cost(u, v, cost_draw());
          else push_cost(v, u, cost_draw());
        end
      end
    end
  endtask

  task automatic run_episode(input int n);
    int order [64];
    int p, s, t, k;
    k = (n < 5) ? n : 5;
    k = $urandom_range((n < 2) ? n : 2, k);
    choose_nodes(k);
    cover_set();
    for (p = 0; p < n; p++) begin
      route_plan[p] = set_nodes[$urandom_range(0, k - 1)];
      order[p] = p;
    end
    for (p = n - 1; p > 0; p--) begin
      s = $urandom_range(0, p);
      t = order[p];
      order[p] = order[s];
      order[s] = t;
    end
    for (p = 0; p < n; p++) push_route(order[p], route_plan[order[p]]);
    ready_len = n;
    push_run(n);
  endtask

  // full-length route: one dominant node and three outliers keep the pass count low
  task automatic big_episode();
    int p, t;
    choose_nodes(4);
    cover_set();
    for (p = 0; p < 64; p++) route_plan[p] = set_nodes[0];
    for (t = 1; t < 4; t++) route_plan[$urandom_range(0, 63)] = set_nodes[t];
    for (p = 63; p >= 0; p--) push_route(p, route_plan[p]);
    ready_len = 64;
    push_run(64);
    push_run(65);   // counts above the route size saturate
    push_run(100);
    push_run(127);
  endtask

  task automatic push_noise();
    case ($urandom_range(0, 2))
      0: push_cost($urandom_range(0, 63), $urandom_range(0, 63), cost_draw());
      1: push_route($urandom_range(0, 63), $urandom_range(0, 63));
      default: push_noop();
    endcase
  endtask

  // request driver
  request_t cur;
  int       gap_left = 0;
  int       burst_left = 0;

  always @(posedge clk_i) begin
    logic fire;
    fire = start_i && !busy_o;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (fire) absorb_request(cur);
      if (fire || !start_i) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (request_q.size() == 0) begin
          start_i <= 1'b0;
        end else if (request_q[0].hold) begin
          start_i <= 1'b0;
          if (tour_expect_q.size() == 0 && !busy_o) void'(request_q.pop_front());
        end else begin
          cur = request_q.pop_front();
          opcode_i      <= cur.op;
          row_node_i    <= cur.row;
          col_node_i    <= cur.col;
          cost_value_i  <= cur.cost;
          route_pos_i   <= cur.pos;
          route_node_i  <= cur.node;
          route_count_i <= cur.count;
          start_i       <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
            gap_left = 0;
          end else begin
            gap_left = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(8, 30);
          end
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    tour_entry_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (tour_expect_q.size() == 0) begin
        $error("unexpected result: out_pos %0d out_node %0d", out_pos_o, out_node_o);
        mismatches++;
      end else begin
        want = tour_expect_q.pop_front();
        if (out_pos_o !== want.pos) begin
          $error("out_pos: expected %0d, got %0d", want.pos, out_pos_o);
          mismatches++;
        end
        if (out_node_o !== want.node) begin
          $error("out_node: expected %0d, got %0d", want.node, out_node_o);
          mismatches++;
        end
        if (total_gain_o !== want.gain) begin
          $error("total_gain: expected %0d, got %0d", want.gain, total_gain_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int  goal, pick, sel, n, cap;
    bit  big_done;
    big_done = 1'b0;

    // directed: unused opcode, empty run, extreme nodes and costs
    push_noop();
    push_run(0);
    push_cost(0, 0, '0);
    push_cost(63, 0, '1);    // mirror load, read back as (0, 63)
    push_cost(63, 63, '1);
    push_route(0, 0);
    push_route(1, 63);
    push_run(1);
    push_run(2);             // short route: no pair to try
    push_cost(21, 21, 16'h5555);
    push_cost(42, 42, 16'haaaa);
    push_cost(21, 42, '1);
    push_cost(0, 21, VAL_W'(1));
    push_cost(63, 42, VAL_W'(1));
    push_cost(63, 21, VAL_W'(100));
    push_cost(0, 42, VAL_W'(100));
    push_route(2, 21);
    push_route(3, 42);
    push_run(4);             // crossed square, gain 131068 from one swap
    push_run(4);             // already optimal
    push_cost(42, 0, '0);    // later load overrides
    push_run(4);
    push_hold();
    ready_len = 4;

    goal = sent + RANDOM_REQUESTS;
    while (sent < goal) begin
      if (!big_done && sent > goal - RANDOM_REQUESTS + 100) begin
        big_episode();
        big_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 19);
      if (sel == 0) n = $urandom_range(1, 2);
      else if (sel < 17) n = $urandom_range(3, 10);
      else n = $urandom_range(11, 24);
      if (pick < 60) begin
        run_episode(n);
      end else if (pick < 72) begin
        cap = (ready_len < 16) ? ready_len : 16;
        if (cap == 0 || $urandom_range(0, 9) == 0) push_run(0);
        else push_run($urandom_range(1, cap));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) push_noise();
      end else begin
        push_hold();
        run_episode(n);
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || start_i || tour_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && tour_expect_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
